// ----- hw/rtl/symbol_code_bit_packer_defines.svh -----
// Assertion macros for the symbol code bit packer.
// Included by symbol_code_bit_packer, the module that carries the concurrent assertions; no other dependencies.
`ifndef SYMBOL_CODE_BIT_PACKER_DEFINES_SVH
`define SYMBOL_CODE_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SCBP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/scbp_pkg.sv -----
// Types, codes and lookup functions for the symbol code bit packer.
// No dependencies; used by the channel interfaces, the block, the checker and the testbench.
package scbp_pkg;

  localparam int SELECT_MAP_DEPTH = 256;
  localparam int MAP_AW = (SELECT_MAP_DEPTH > 1) ? $clog2(SELECT_MAP_DEPTH) : 1;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  localparam logic [1:0] KIND_GENERAL  = 2'd0;
  localparam logic [1:0] KIND_DNA      = 2'd1;
  localparam logic [1:0] KIND_PROTEIN  = 2'd2;
  localparam logic [1:0] KIND_SELECTED = 2'd3;

  localparam logic STATUS_BYTE    = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_ALPHABET_KIND     = 1'd0;
  localparam cfg_index_t REG_SELECT_CODE_WIDTH = 1'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_char;
    logic [7:0] load_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       status;
  } out_word_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
    logic [3:0] width;
  } lookup_t;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    fold_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    is_white = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic lookup_t dna_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit   = 1'b1;
    r.width = 4'd3;
    unique case (fold_upper(c))
      "A": r.code = 8'd0;
      "C": r.code = 8'd1;
      "G": r.code = 8'd2;
      "T": r.code = 8'd3;
      "N": r.code = 8'd4;
      default: begin
        r.code = 8'd0;
        r.hit  = 1'b0;
      end
    endcase
    dna_lookup = r;
  endfunction

  function automatic lookup_t protein_lookup(input logic [7:0] c);
    lookup_t r;
    r.hit   = 1'b1;
    r.width = 4'd5;
    unique case (fold_upper(c))
      "A": r.code = 8'd0;
      "C": r.code = 8'd1;
      "D": r.code = 8'd2;
      "E": r.code = 8'd3;
      "F": r.code = 8'd4;
      "G": r.code = 8'd5;
      "H": r.code = 8'd6;
      "I": r.code = 8'd7;
      "K": r.code = 8'd8;
      "L": r.code = 8'd9;
      "M": r.code = 8'd10;
      "N": r.code = 8'd11;
      "O": r.code = 8'd12;
      "P": r.code = 8'd13;
      "Q": r.code = 8'd14;
      "R": r.code = 8'd15;
      "S": r.code = 8'd16;
      "T": r.code = 8'd17;
      "U": r.code = 8'd18;
      "V": r.code = 8'd19;
      "W": r.code = 8'd20;
      "Y": r.code = 8'd21;
      default: begin
        r.code = 8'd0;
        r.hit  = 1'b0;
      end
    endcase
    protein_lookup = r;
  endfunction

endpackage

// ----- hw/rtl/scbp_in_if.sv -----
// Input channel of the symbol code bit packer: valid, ready and one input word.
// Depends on scbp_pkg for the word type.
interface scbp_in_if;
  import scbp_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/scbp_out_if.sv -----
// Result channel of the symbol code bit packer: valid, ready and one result word.
// Depends on scbp_pkg for the word type.
interface scbp_out_if;
  import scbp_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/symbol_code_bit_packer.sv -----
// Symbol code bit packer: a word is taken at an edge where valid and ready are both high.
// That edge loads the word and its select map read into the first stage; the lookup and
// leftover update are combinational, and the result register loads once the stage advances.
// Throughput is one word per cycle; the input stalls only while both stages are full and
// the result is not taken. Reset (synchronous, active high) clears the leftover bits, the
// registers and every select map valid bit at once, so words are taken straight after it.
`include "symbol_code_bit_packer_defines.svh"
module symbol_code_bit_packer (
  input  logic                clk,
  input  logic                rst,
  scbp_in_if.sink             chars,
  scbp_out_if.source          codes,
  input  logic                cfg_we,
  input  scbp_pkg::cfg_index_t cfg_index,
  input  logic [3:0]          cfg_data
);
  import scbp_pkg::*;

  // Configuration registers.
  logic [1:0] alphabet_kind;
  logic [3:0] select_code_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_kind     <= KIND_GENERAL;
      select_code_width <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHABET_KIND:     alphabet_kind     <= cfg_data[1:0];
        REG_SELECT_CODE_WIDTH: select_code_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // The first stage holds the accepted word together with the registered read of the
  // select map. The map entry is read at the same edge at which the word is taken, so a
  // load is visible to the very next word without any forwarding.
  logic              s1_valid;
  logic [1:0]        s1_mode;
  logic [7:0]        s1_char;
  logic              s1_hit;
  logic [7:0]        s1_index;
  logic              s1_adv;
  logic              in_accept;

  logic [SELECT_MAP_DEPTH-1:0] map_valid;
  logic [7:0]                  map_mem [SELECT_MAP_DEPTH];
  logic [MAP_AW-1:0]           map_addr;
  logic                        map_in_range;

  // The result register is free, or is being emptied, so the first stage can move on.
  logic out_valid;
  assign s1_adv       = !out_valid || codes.ready;
  assign chars.ready  = !s1_valid || s1_adv;
  assign in_accept    = chars.valid && chars.ready;
  assign map_addr     = chars.data.in_char[MAP_AW-1:0];
  assign map_in_range = {1'b0, chars.data.in_char} < 9'(SELECT_MAP_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      map_valid <= '0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      // Only the first load of a character sets its entry.
      if (in_accept && chars.data.mode == MODE_LOAD && map_in_range && !map_valid[map_addr]) begin
        map_valid[map_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode  <= chars.data.mode;
      s1_char  <= chars.data.in_char;
      s1_hit   <= map_in_range && map_valid[map_addr];
      s1_index <= map_mem[map_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && chars.data.mode == MODE_LOAD && map_in_range && !map_valid[map_addr]) begin
      map_mem[map_addr] <= chars.data.load_index;
    end
  end

  // Second stage: code lookup and packing against the leftover accumulator.
  logic [6:0]  leftover_bits;
  logic [2:0]  leftover_count;
  logic [6:0]  leftover_bits_next;
  logic [2:0]  leftover_count_next;
  logic        leftover_update;
  logic        res_fire;
  out_word_t   res_word;

  lookup_t     lk;
  logic [3:0]  sel_width;
  logic [14:0] acc;
  logic [14:0] flush_shifted;
  logic [3:0]  total;
  logic [2:0]  rest;

  // Selected mode clamps the width into one to eight bits and drops the index bits above it.
  always_comb begin
    priority if (select_code_width == 4'd0) begin
      sel_width = 4'd1;
    end else if (select_code_width > 4'd8) begin
      sel_width = 4'd8;
    end else begin
      sel_width = select_code_width;
    end
  end

  always_comb begin
    unique case (alphabet_kind)
      KIND_GENERAL: begin
        lk.hit   = (s1_char >= 8'h20) && (s1_char <= 8'h7E);
        lk.code  = s1_char;
        lk.width = 4'd8;
      end
      KIND_DNA:     lk = dna_lookup(s1_char);
      KIND_PROTEIN: lk = protein_lookup(s1_char);
      default: begin
        lk.hit   = s1_hit;
        lk.code  = s1_index & 8'((9'd1 << sel_width) - 9'd1);
        lk.width = sel_width;
      end
    endcase
  end

  assign acc           = ({8'd0, leftover_bits} << lk.width) | {7'd0, lk.code};
  assign total         = {1'b0, leftover_count} + lk.width;
  assign rest          = total[2:0];
  assign flush_shifted = {8'd0, leftover_bits} << (4'd8 - {1'b0, leftover_count});

  always_comb begin
    res_fire            = 1'b0;
    res_word.out_byte   = 8'd0;
    res_word.status     = STATUS_BYTE;
    leftover_update     = 1'b0;
    leftover_bits_next  = leftover_bits;
    leftover_count_next = leftover_count;
    unique case (s1_mode)
      MODE_FLUSH: begin
        if (leftover_count != 3'd0) begin
          res_fire            = 1'b1;
          res_word.out_byte   = flush_shifted[7:0];
          leftover_update     = 1'b1;
          leftover_bits_next  = 7'd0;
          leftover_count_next = 3'd0;
        end
      end
      MODE_ENCODE: begin
        // Whitespace is skipped silently in every kind but general printable.
        priority if (alphabet_kind != KIND_GENERAL && is_white(s1_char)) begin
          res_fire = 1'b0;
        end else if (!lk.hit) begin
          res_fire        = 1'b1;
          res_word.status = STATUS_INVALID;
        end else if (total >= 4'd8) begin
          res_fire            = 1'b1;
          res_word.out_byte   = 8'(acc >> rest);
          leftover_update     = 1'b1;
          leftover_bits_next  = acc[6:0] & ((7'd1 << rest) - 7'd1);
          leftover_count_next = rest;
        end else begin
          leftover_update     = 1'b1;
          leftover_bits_next  = acc[6:0];
          leftover_count_next = total[2:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= 7'd0;
      leftover_count <= 3'd0;
      out_valid      <= 1'b0;
    end else begin
      if (s1_valid && s1_adv && leftover_update) begin
        leftover_bits  <= leftover_bits_next;
        leftover_count <= leftover_count_next;
      end
      if (s1_adv) begin
        out_valid <= s1_valid && res_fire;
      end
    end
  end

  out_word_t out_word;
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid && res_fire) begin
      out_word <= res_word;
    end
  end

  assign codes.valid = out_valid;
  assign codes.data  = out_word;

  // Held bits above the held count are always zero.
  `SCBP_ASSERT_IMPL(a_leftover_clean, clk, rst, 1'b1,
                    (leftover_bits >> leftover_count) == 7'd0, "leftover bits above count")
  // A rejected character never carries a byte.
  `SCBP_ASSERT_IMPL(a_invalid_zero, clk, rst, out_valid && out_word.status == STATUS_INVALID,
                    out_word.out_byte == 8'd0, "invalid word with data")
  // Input back-pressure only comes from a stalled result.
  `SCBP_ASSERT_IMPL(a_ready_cause, clk, rst, !chars.ready,
                    s1_valid && out_valid && !codes.ready, "ready low without stall")
  // A stalled first stage keeps its word.
  `SCBP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_adv,
                    s1_valid && $stable(s1_mode) && $stable(s1_char), "first stage lost word")

endmodule

// ----- verif/symbol_code_bit_packer_checker.sv -----
// Checker for the symbol code bit packer: watches both channels and the register port,
// predicts every packed byte and compares it with what the block returns.
// Depends on scbp_pkg and the scbp_in_if and scbp_out_if channel interfaces.
module symbol_code_bit_packer_checker
  import scbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  scbp_in_if         chars,
  scbp_out_if        codes,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  logic [3:0] cfg_data,
  output int         mismatch_count,
  output int         awaited_count
);

  logic [1:0] kind_reg;
  logic [3:0] width_reg;
  logic [6:0] held_bits;
  logic [2:0] held_count;
  logic       map_valid [SELECT_MAP_DEPTH];
  logic [7:0] map_index [SELECT_MAP_DEPTH];
  out_word_t  awaited_bytes [$];
  int         errors = 0;
  string      dna_letters = "ACGTN";
  string      protein_letters = "ACDEFGHIKLMNOPQRSTUVWY";

  assign mismatch_count = errors;

  // Applies one input word to the predicted state; returns 1 when it yields a result word.
  function automatic bit pack_symbol(input in_word_t w, output out_word_t res);
    logic [7:0]  c;
    logic [7:0]  u;
    logic [7:0]  code;
    logic [3:0]  wd;
    logic [3:0]  total;
    logic [3:0]  rest;
    logic [15:0] acc;
    bit          hit;
    res        = '0;
    res.status = STATUS_BYTE;
    c          = w.in_char;
    code       = '0;
    wd         = '0;
    hit        = 1'b0;
    if (w.mode == MODE_LOAD) begin
      if (int'(c) < SELECT_MAP_DEPTH && !map_valid[c]) begin
        map_valid[c] = 1'b1;
        map_index[c] = w.load_index;
      end
      return 1'b0;
    end
    if (w.mode == MODE_FLUSH) begin
      if (held_count == 3'd0)
        return 1'b0;
      res.out_byte = 8'(16'(held_bits) << (4'd8 - {1'b0, held_count}));
      held_bits    = '0;
      held_count   = '0;
      return 1'b1;
    end
    if (w.mode != MODE_ENCODE)
      return 1'b0;
    // Outside general mode whitespace is skipped silently.
    if (kind_reg != KIND_GENERAL && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)))
      return 1'b0;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    case (kind_reg)
      KIND_GENERAL: begin
        hit  = (c >= 8'h20 && c <= 8'h7E);
        code = c;
        wd   = 4'd8;
      end
      KIND_DNA: begin
        wd = 4'd3;
        for (int i = 0; i < dna_letters.len(); i++) begin
          if (u == dna_letters[i]) begin
            hit  = 1'b1;
            code = 8'(i);
          end
        end
      end
      KIND_PROTEIN: begin
        wd = 4'd5;
        for (int i = 0; i < protein_letters.len(); i++) begin
          if (u == protein_letters[i]) begin
            hit  = 1'b1;
            code = 8'(i);
          end
        end
      end
      default: begin
        wd = (width_reg == 4'd0) ? 4'd1 : (width_reg > 4'd8) ? 4'd8 : width_reg;
        if (int'(c) < SELECT_MAP_DEPTH && map_valid[c]) begin
          hit  = 1'b1;
          code = map_index[c] & 8'((16'd1 << wd) - 16'd1);
        end
      end
    endcase
    if (!hit) begin
      res.out_byte = 8'd0;
      res.status   = STATUS_INVALID;
      return 1'b1;
    end
    acc   = (16'(held_bits) << wd) | 16'(code);
    total = {1'b0, held_count} + wd;
    if (total >= 4'd8) begin
      rest         = total - 4'd8;
      res.out_byte = 8'(acc >> rest);
      held_bits    = 7'(acc & ((16'd1 << rest) - 16'd1));
      held_count   = 3'(rest);
      return 1'b1;
    end
    held_bits  = acc[6:0];
    held_count = total[2:0];
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_word_t res;
    out_word_t head;
    if (rst) begin
      kind_reg   = KIND_GENERAL;
      width_reg  = 4'd8;
      held_bits  = '0;
      held_count = '0;
      for (int i = 0; i < SELECT_MAP_DEPTH; i++) begin
        map_valid[i] = 1'b0;
        map_index[i] = 8'd0;
      end
      awaited_bytes.delete();
    end else begin
      // Results are compared before the new word is predicted: they belong to older words.
      if (codes.valid && codes.ready) begin
        if (awaited_bytes.size() == 0) begin
          errors++;
          $error("unexpected result word: out_byte %02h status %0b",
                 codes.data.out_byte, codes.data.status);
        end else begin
          head = awaited_bytes.pop_front();
          if (codes.data.out_byte !== head.out_byte) begin
            errors++;
            $error("out_byte mismatch: expected %02h, actual %02h",
                   head.out_byte, codes.data.out_byte);
          end
          if (codes.data.status !== head.status) begin
            errors++;
            $error("status mismatch: expected %0b, actual %0b",
                   head.status, codes.data.status);
          end
        end
      end
      if (chars.valid && chars.ready) begin
        if (pack_symbol(chars.data, res))
          awaited_bytes = {awaited_bytes, res};
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ALPHABET_KIND:     kind_reg  = cfg_data[1:0];
          REG_SELECT_CODE_WIDTH: width_reg = cfg_data;
          default: ;
        endcase
      end
    end
    awaited_count = awaited_bytes.size();
  end

endmodule

// ----- verif/symbol_code_bit_packer_test.sv -----
// Testbench top for the symbol code bit packer: clock, reset, register writes and stimulus.
// Depends on scbp_pkg, the channel interfaces, the block and symbol_code_bit_packer_checker.
module symbol_code_bit_packer_test;
  import scbp_pkg::*;

  // Generous ceiling on the run, well above the slowest correct run with both sides stalling.
  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_WORDS = 1200;
  localparam int SEGMENTS     = 16;

  // The spare mode value is not a command; the block must ignore such a word.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic [3:0] cfg_data;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatch_count;
  int         awaited_count;

  // Characters that have been given a select map entry, so that selected-mode
  // stimulus can mostly encode characters the block will accept.
  bit         loaded_seen [256];
  logic [7:0] loaded_chars [$];

  string      dna_syms = "ACGTN";
  string      protein_syms = "ACDEFGHIKLMNOPQRSTUVWY";

  scbp_in_if  chars_if ();
  scbp_out_if codes_if ();

  symbol_code_bit_packer DUT (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .codes     (codes_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  symbol_code_bit_packer_checker packer_check (
    .clk            (clk),
    .rst            (rst),
    .chars          (chars_if),
    .codes          (codes_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Should the block hang, the run is stopped here and counted as failed.
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // The receiving side: ready is redrawn on every edge according to the current stall rate.
  initial begin
    codes_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      codes_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one word, possibly after some idle cycles, and returns at the edge where it is
  // taken. Valid is left high so that a following word can go out back to back.
  task automatic send_word(input logic [1:0] mode, input logic [7:0] ch,
                           input logic [7:0] idx);
    in_word_t w;
    w.mode       = mode;
    w.in_char    = ch;
    w.load_index = idx;
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.data  <= w;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    if (mode == MODE_LOAD && !loaded_seen[ch]) begin
      loaded_seen[ch] = 1'b1;
      loaded_chars    = {loaded_chars, ch};
    end
  endtask

  task automatic encode(input logic [7:0] ch);
    send_word(MODE_ENCODE, ch, 8'($urandom_range(254)));
  endtask

  task automatic flush();
    send_word(MODE_FLUSH, 8'($urandom_range(255)), 8'($urandom_range(254)));
  endtask

  // Brings the block to rest: no word offered, every predicted byte returned, and a few
  // further cycles so that a word with no result has left the two-stage pipeline too.
  // Sampling at the falling edge keeps clear of the checker's updates.
  task automatic settle();
    chars_if.valid <= 1'b0;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The task waits with the enable low after each write, so that back-to-back writes never
  // lower and raise the enable within the same step.
  task automatic write_reg(input cfg_index_t idx, input logic [3:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One random word for the given alphabet kind. Most are well-formed symbols of the
  // alphabet in force; the rest are flushes, map loads, whitespace, stray bytes and the
  // spare mode.
  task automatic send_random_word(input logic [1:0] kind);
    int         r;
    logic [7:0] ch;
    logic [7:0] idx;
    r   = $urandom_range(99);
    ch  = 8'($urandom_range(255));
    idx = 8'($urandom_range(254));
    if (r < 3) begin
      send_word(MODE_SPARE, ch, idx);
    end else if (r < 11) begin
      send_word(MODE_FLUSH, ch, idx);
    end else if (r < ((kind == KIND_SELECTED) ? 30 : 13)) begin
      // Loads favour printable characters and the extreme indexes.
      if ($urandom_range(3) == 0)
        idx = $urandom_range(1) ? 8'd0 : 8'd254;
      if ($urandom_range(9) < 7)
        ch = 8'($urandom_range(8'h21, 8'h7E));
      send_word(MODE_LOAD, ch, idx);
    end else if (r < 37) begin
      send_word(MODE_ENCODE, ch, idx);
    end else if (r < 42) begin
      ch = ($urandom_range(5) == 5) ? 8'h20 : 8'($urandom_range(8'h09, 8'h0D));
      send_word(MODE_ENCODE, ch, idx);
    end else begin
      case (kind)
        KIND_GENERAL: ch = 8'($urandom_range(8'h20, 8'h7E));
        KIND_DNA: begin
          ch = dna_syms[$urandom_range(dna_syms.len() - 1)];
          if ($urandom_range(1)) ch = ch + 8'h20;
        end
        KIND_PROTEIN: begin
          ch = protein_syms[$urandom_range(protein_syms.len() - 1)];
          if ($urandom_range(1)) ch = ch + 8'h20;
        end
        default: begin
          if (loaded_chars.size() != 0)
            ch = loaded_chars[$urandom_range(loaded_chars.size() - 1)];
        end
      endcase
      send_word(MODE_ENCODE, ch, idx);
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ALPHABET_KIND;
    cfg_data       <= 4'd0;
    chars_if.valid <= 1'b0;
    chars_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // General printable mode straight out of reset: both ends of the printable range, the bytes
    // just outside it, the bytes 00 and FF, a flush with nothing held and the spare mode.
    encode(8'h20);
    encode(8'h7E);
    encode(8'h1F);
    encode(8'h7F);
    encode(8'h00);
    encode(8'hFF);
    flush();
    send_word(MODE_SPARE, 8'h41, 8'd0);

    // DNA: every base in mixed case, whitespace that must be skipped, a stray letter,
    // and a flush that pads the held bits with zeros.
    settle();
    write_reg(REG_ALPHABET_KIND, 4'(KIND_DNA));
    encode("a");
    encode("C");
    encode("g");
    encode("T");
    encode("n");
    encode(8'h20);
    encode(8'h09);
    encode(8'h0D);
    encode("x");
    flush();

    // Protein: the last letter in lower case, the odd letter O, and a letter outside the set.
    settle();
    write_reg(REG_ALPHABET_KIND, 4'(KIND_PROTEIN));
    encode("y");
    encode("O");
    encode("b");

    // Selected alphabet with a zero width, which must act as one bit. The second load of
    // the same character is to be ignored, and the top map entry is used as well.
    settle();
    write_reg(REG_ALPHABET_KIND, 4'(KIND_SELECTED));
    write_reg(REG_SELECT_CODE_WIDTH, 4'd0);
    send_word(MODE_LOAD, "A", 8'd254);
    send_word(MODE_LOAD, "A", 8'd1);
    send_word(MODE_LOAD, 8'hFF, 8'd0);
    encode("A");
    encode(8'hFF);
    encode("B");

    // A width beyond eight acts as eight and takes in the bits still held from the protein and
    // one-bit codes; the bits it leaves held are carried across the change of kind.
    settle();
    write_reg(REG_SELECT_CODE_WIDTH, 4'd15);
    encode("A");
    settle();
    write_reg(REG_ALPHABET_KIND, 4'(KIND_DNA));
    encode("G");
    flush();

    // Random part: four blocks of idling behaviour, each running every alphabet kind.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      logic [1:0] kind;
      kind = 2'(seg % 4);
      settle();
      case ((seg / 4) % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      write_reg(REG_ALPHABET_KIND, 4'(kind));
      if (kind == KIND_SELECTED) begin
        case (seg / 4)
          0:       write_reg(REG_SELECT_CODE_WIDTH, 4'd1);
          1:       write_reg(REG_SELECT_CODE_WIDTH, 4'($urandom_range(2, 7)));
          2:       write_reg(REG_SELECT_CODE_WIDTH, 4'd8);
          default: write_reg(REG_SELECT_CODE_WIDTH, 4'd15);
        endcase
      end
      repeat (RANDOM_WORDS / SEGMENTS) send_random_word(kind);
    end

    settle();
    @(negedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
